FILE: hdl/bhtq_pkg.sv
// Shared types and codes for the binary heap timer queue.
package bhtq_pkg;

  localparam int unsigned ID_W = 5;
  localparam int unsigned NUM_IDS = 32;
  localparam int unsigned TIME_W = 32;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_TICK = 2'd2,
    OP_PEEK = 2'd3
  } opcode_t;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_ID    = 3'd3;
  localparam logic [2:0] ST_MORE  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UP,
    S_DLOAD,
    S_DOWN,
    S_TICK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] dl;
    logic [TIME_W-1:0] per;
    logic [ID_W-1:0]   own;
  } slot_t;

endpackage

FILE: hdl/binary_heap_timer_queue_top.sv
// Top level of the binary min-heap timer queue.
// Timers sit in a row of heap slot cells; a sequencer walks the heap one level per
// cycle, moving one slot per cycle through the row. An item is taken only when the
// queue is idle. Add sifts the new timer up; delete sifts the moved last slot up,
// then down; peek reads the root. A tick fires up to MAX_FIRES due timers, sifting
// each re-armed or replacement root down, and waits while the result side stalls.
module binary_heap_timer_queue_top
  import bhtq_pkg::*;
#(
  parameter int unsigned CAPACITY  = 32,
  parameter int unsigned MAX_FIRES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [4:0]  timer_id,
  input  logic [31:0] deadline,
  input  logic [31:0] period,
  input  logic [31:0] now_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        event_valid,
  output logic [4:0]  event_id,
  output logic [31:0] event_deadline,
  output logic        event_periodic,
  output logic [5:0]  queue_count,
  output logic        last
);

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = PW + 2;
  localparam int unsigned NW = $clog2(MAX_FIRES + 1);

  state_t state, state_next;
  opcode_t op, op_next;
  logic [ID_W-1:0] id_r, id_r_next;
  logic [TIME_W-1:0] dl_r, dl_r_next, per_r, per_r_next, now_r, now_r_next;
  slot_t node, node_next;
  logic [PW-1:0] pos, pos_next, orig_pos, orig_pos_next;
  logic down_after, down_after_next;
  logic [NW-1:0] n, n_next;
  logic [ID_W-1:0] pf_id, pf_id_next;
  logic [TIME_W-1:0] pf_dl, pf_dl_next;
  logic pf_per, pf_per_next;
  logic [2:0] res_status, res_status_next;
  logic res_ev, res_ev_next;
  logic [ID_W-1:0] res_id, res_id_next;
  logic [TIME_W-1:0] res_dl, res_dl_next;
  logic [NUM_IDS-1:0] active, active_next;
  logic [CW-1:0] count, count_next;
  logic [PW-1:0] posid [NUM_IDS];

  slot_t slots [CAPACITY];
  logic wr_en;
  logic [PW-1:0] wr_idx;
  slot_t wr_data;
  logic pw_en;
  logic [ID_W-1:0] pw_id;
  logic [PW-1:0] pw_val;

  logic emit, e_ev, e_per, e_last;
  logic [2:0] e_status;
  logic [ID_W-1:0] e_id;
  logic [TIME_W-1:0] e_dl;
  logic out_free;

  logic [PW-1:0] par;
  logic [XW-1:0] lx, rx, mx, cntx;
  slot_t sl, sr, sm, s0, slast;
  logic [PW-1:0] lastpos, dpos;
  logic due, cont;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_row
    bhtq_cell u_cell (
      .clk   (clk),
      .we    (wr_en && (wr_idx == PW'(g))),
      .wdata (wr_data),
      .q     (slots[g])
    );
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  assign par     = PW'((pos - PW'(1)) >> 1);
  assign lx      = {1'b0, pos, 1'b1};
  assign rx      = lx + XW'(1);
  assign cntx    = XW'(count);
  assign sl      = slots[lx[PW-1:0]];
  assign sr      = slots[rx[PW-1:0]];
  assign mx      = (sl.dl < sr.dl) ? lx : rx;
  assign sm      = slots[mx[PW-1:0]];
  assign s0      = slots[0];
  assign lastpos = PW'(count - CW'(1));
  assign slast   = slots[lastpos];
  assign due     = (count != '0) && (s0.dl <= now_r);
  assign cont    = (n < NW'(MAX_FIRES)) && due;

  always_comb begin
    state_next = state;
    op_next = op;
    id_r_next = id_r;
    dl_r_next = dl_r;
    per_r_next = per_r;
    now_r_next = now_r;
    node_next = node;
    pos_next = pos;
    orig_pos_next = orig_pos;
    down_after_next = down_after;
    n_next = n;
    pf_id_next = pf_id;
    pf_dl_next = pf_dl;
    pf_per_next = pf_per;
    res_status_next = res_status;
    res_ev_next = res_ev;
    res_id_next = res_id;
    res_dl_next = res_dl;
    active_next = active;
    count_next = count;
    wr_en = 1'b0;
    wr_idx = pos;
    wr_data = node;
    pw_en = 1'b0;
    pw_id = node.own;
    pw_val = pos;
    emit = 1'b0;
    e_status = ST_OK;
    e_ev = 1'b0;
    e_id = '0;
    e_dl = '0;
    e_per = 1'b0;
    e_last = 1'b1;
    dpos = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next = opcode_t'(opcode);
          id_r_next = timer_id;
          dl_r_next = deadline;
          per_r_next = period;
          now_r_next = now_time;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        res_status_next = ST_OK;
        res_ev_next = 1'b0;
        res_id_next = '0;
        res_dl_next = '0;
        state_next = S_EMIT;
        unique case (op)
          OP_ADD: begin
            if (active[id_r]) begin
              res_status_next = ST_ID;
            end else if (count >= CW'(CAPACITY)) begin
              res_status_next = ST_FULL;
            end else begin
              count_next = count + CW'(1);
              active_next[id_r] = 1'b1;
              node_next = '{dl: dl_r, per: per_r, own: id_r};
              pos_next = PW'(count);
              down_after_next = 1'b0;
              state_next = S_UP;
            end
          end
          OP_DEL: begin
            if (!active[id_r] || count == '0) begin
              res_status_next = ST_ID;
            end else begin
              dpos = posid[id_r];
              if (CW'(dpos) >= count) dpos = lastpos;
              active_next[id_r] = 1'b0;
              count_next = count - CW'(1);
              if (dpos != lastpos) begin
                node_next = slast;
                pos_next = dpos;
                orig_pos_next = dpos;
                down_after_next = 1'b1;
                state_next = S_UP;
              end
            end
          end
          OP_TICK: begin
            n_next = '0;
            state_next = S_TICK;
          end
          OP_PEEK: begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
            end else begin
              res_ev_next = 1'b1;
              res_id_next = s0.own;
              res_dl_next = s0.dl;
            end
          end
          default: ;
        endcase
      end
      S_UP: begin
        wr_en = 1'b1;
        pw_en = 1'b1;
        if (pos != '0 && node.dl < slots[par].dl) begin
          wr_data = slots[par];
          pw_id = slots[par].own;
          pos_next = par;
        end else begin
          state_next = down_after ? S_DLOAD : S_EMIT;
        end
      end
      S_DLOAD: begin
        node_next = slots[orig_pos];
        pos_next = orig_pos;
        state_next = S_DOWN;
      end
      S_DOWN: begin
        wr_en = 1'b1;
        pw_en = 1'b1;
        if (rx < cntx && !(node.dl < sm.dl)) begin
          wr_data = sm;
          pw_id = sm.own;
          pos_next = mx[PW-1:0];
        end else if (rx >= cntx && lx < cntx && sl.dl < node.dl) begin
          wr_data = sl;
          pw_id = sl.own;
          pos_next = lx[PW-1:0];
        end else begin
          state_next = (op == OP_TICK) ? S_TICK : S_EMIT;
        end
      end
      S_TICK: begin
        if (n == '0 && !cont) begin
          res_status_next = (count == '0) ? ST_EMPTY : ST_OK;
          res_ev_next = 1'b0;
          res_id_next = '0;
          res_dl_next = '0;
          state_next = S_EMIT;
        end else if (n == '0 || out_free) begin
          if (n != '0) begin
            emit = 1'b1;
            e_status = (!cont && due) ? ST_MORE : ST_OK;
            e_ev = 1'b1;
            e_id = pf_id;
            e_dl = pf_dl;
            e_per = pf_per;
            e_last = !cont;
            if (!cont) state_next = S_IDLE;
          end
          if (cont) begin
            n_next = n + NW'(1);
            pf_id_next = s0.own;
            pf_dl_next = s0.dl;
            pf_per_next = (s0.per != '0);
            pos_next = '0;
            if (s0.per != '0) begin
              node_next = '{dl: s0.dl + s0.per, per: s0.per, own: s0.own};
              state_next = S_DOWN;
            end else begin
              count_next = count - CW'(1);
              active_next[s0.own] = 1'b0;
              if (lastpos != '0) begin
                node_next = slast;
                state_next = S_DOWN;
              end
            end
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          e_status = res_status;
          e_ev = res_ev;
          e_id = res_id;
          e_dl = res_dl;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      active <= active_next;
      count <= count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    op <= op_next;
    id_r <= id_r_next;
    dl_r <= dl_r_next;
    per_r <= per_r_next;
    now_r <= now_r_next;
    node <= node_next;
    pos <= pos_next;
    orig_pos <= orig_pos_next;
    down_after <= down_after_next;
    n <= n_next;
    pf_id <= pf_id_next;
    pf_dl <= pf_dl_next;
    pf_per <= pf_per_next;
    res_status <= res_status_next;
    res_ev <= res_ev_next;
    res_id <= res_id_next;
    res_dl <= res_dl_next;
    if (pw_en) posid[pw_id] <= pw_val;
    if (emit) begin
      status <= e_status;
      event_valid <= e_ev;
      event_id <= e_id;
      event_deadline <= e_dl;
      event_periodic <= e_per;
      queue_count <= 6'(count);
      last <= e_last;
    end
  end

endmodule

FILE: hdl/bhtq_cell.sv
// One heap slot: deadline, period and owner id.
module bhtq_cell
  import bhtq_pkg::*;
(
  input  logic  clk,
  input  logic  we,
  input  slot_t wdata,
  output slot_t q
);

  slot_t data;

  always_ff @(posedge clk) begin
    if (we) begin
      data <= wdata;
    end
  end

  assign q = data;

endmodule

FILE: hdl/bhtq_checker.sv
// Port-level checks for the timer queue, bound to the top level.
module bhtq_checker
  import bhtq_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic        event_valid,
  input logic        event_periodic,
  input logic [5:0]  queue_count,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(queue_count))
    else $error("stalled transfer changed");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(queue_count) <= CAPACITY)
    else $error("count above capacity");

  a_periodic: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_periodic |-> event_valid)
    else $error("periodic flag without event");

  a_more: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_MORE |-> last && event_valid)
    else $error("more-pending on wrong result");

  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY || status == ST_FULL || status == ST_ID)
      |-> !event_valid && last)
    else $error("error result carries event");

endmodule

bind binary_heap_timer_queue_top bhtq_checker #(.CAPACITY(CAPACITY)) u_bhtq_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .event_valid    (event_valid),
  .event_periodic (event_periodic),
  .queue_count    (queue_count),
  .last           (last)
);
